[rtl/e2q_pkg.sv]
// Package for the Euler angle to quaternion converter.
// Holds the internal fixed-point constants and the arctangent table.
// No dependencies.
`timescale 1ns / 1ps
package e2q_pkg;
    localparam int ANGLE_WIDTH_DEF = 16;
    localparam int OUT_WIDTH_DEF = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int FRAC = 30;
    localparam int IW = 34;
    localparam logic signed [IW-1:0] HALF_PI = 34'sd1686629713;
    localparam logic signed [IW-1:0] INV_GAIN = 34'sd652032874;

    typedef logic signed [IW-1:0] fix_t;

    typedef enum logic [1:0] {
        REG_MID = 2'd0,
        REG_POS = 2'd1,
        REG_NEG = 2'd2
    } region_t;

    function automatic fix_t atan_lut(input logic [4:0] idx);
        fix_t r;
        case (idx)
            5'd0: r = 34'sd843314856;
            5'd1: r = 34'sd497837829;
            5'd2: r = 34'sd263043836;
            5'd3: r = 34'sd133525158;
            5'd4: r = 34'sd67021686;
            5'd5: r = 34'sd33543515;
            5'd6: r = 34'sd16775850;
            5'd7: r = 34'sd8388437;
            5'd8: r = 34'sd4194282;
            5'd9: r = 34'sd2097149;
            5'd10: r = 34'sd1048575;
            5'd11: r = 34'sd524287;
            5'd12: r = 34'sd262143;
            5'd13: r = 34'sd131071;
            5'd14: r = 34'sd65535;
            5'd15: r = 34'sd32767;
            5'd16: r = 34'sd16383;
            5'd17: r = 34'sd8191;
            5'd18: r = 34'sd4095;
            5'd19: r = 34'sd2047;
            5'd20: r = 34'sd1023;
            5'd21: r = 34'sd511;
            5'd22: r = 34'sd255;
            5'd23: r = 34'sd127;
            5'd24: r = 34'sd63;
            5'd25: r = 34'sd31;
            5'd26: r = 34'sd15;
            5'd27: r = 34'sd7;
            5'd28: r = 34'sd3;
            5'd29: r = 34'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage

[rtl/e2q_cordic.sv]
// Pipelined rotation-mode CORDIC giving sine and cosine of a half angle.
// One micro-rotation per stage; depends on e2q_pkg.
`timescale 1ns / 1ps
module e2q_cordic #(
    parameter int ANGLE_WIDTH = e2q_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STEPS = e2q_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [ANGLE_WIDTH-1:0] angle,
    output e2q_pkg::fix_t                 sin_val,
    output e2q_pkg::fix_t                 cos_val
);
    import e2q_pkg::*;

    localparam int NS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    fix_t    x_reg [0:NS];
    fix_t    y_reg [0:NS];
    fix_t    z_reg [0:NS];
    region_t r_reg [0:NS];
    fix_t    h;
    fix_t    z0;
    region_t r0;

    always_comb
    begin
        h = fix_t'(angle) <<< (32 - ANGLE_WIDTH);
        if (h > HALF_PI)
        begin
            z0 = h - HALF_PI;
            r0 = REG_POS;
        end
        else if (h < -HALF_PI)
        begin
            z0 = h + HALF_PI;
            r0 = REG_NEG;
        end
        else
        begin
            z0 = h;
            r0 = REG_MID;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= INV_GAIN;
            y_reg[0] <= '0;
            z_reg[0] <= z0;
            r_reg[0] <= r0;
        end
    end

    for (genvar i = 0; i < NS; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[i+1] <= r_reg[i];
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_lut(5'(i));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_lut(5'(i));
                end
            end
        end
    end

    always_comb
    begin
        case (r_reg[NS])
            REG_POS:
            begin
                sin_val = x_reg[NS];
                cos_val = -y_reg[NS];
            end
            REG_NEG:
            begin
                sin_val = -x_reg[NS];
                cos_val = y_reg[NS];
            end
            default:
            begin
                sin_val = y_reg[NS];
                cos_val = x_reg[NS];
            end
        endcase
    end
endmodule

[rtl/e2q_combine.sv]
// Pipelined quaternion product of the three half-angle sine/cosine pairs.
// Stage 1 pair products, stage 2 triple products, stage 3 sum and rounding.
// Depends on e2q_pkg.
`timescale 1ns / 1ps
module e2q_combine #(
    parameter int OUT_WIDTH = e2q_pkg::OUT_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        en,
    input  e2q_pkg::fix_t               sx,
    input  e2q_pkg::fix_t               cx,
    input  e2q_pkg::fix_t               sy,
    input  e2q_pkg::fix_t               cy,
    input  e2q_pkg::fix_t               sz,
    input  e2q_pkg::fix_t               cz,
    output logic signed [OUT_WIDTH-1:0] qx,
    output logic signed [OUT_WIDTH-1:0] qy,
    output logic signed [OUT_WIDTH-1:0] qz,
    output logic signed [OUT_WIDTH-1:0] qw
);
    import e2q_pkg::*;

    localparam int PW = 2 * IW;
    localparam int SH = 2 * FRAC - (OUT_WIDTH - 2);
    localparam logic signed [PW:0] RND2 = (PW + 1)'(1) <<< (SH - 1);
    localparam logic signed [PW:0] LIM = (PW + 1)'(1) <<< (OUT_WIDTH - 2);
    localparam logic signed [PW-1:0] RND1 = PW'(1) <<< (FRAC - 1);

    // Pair products: sx*cy, cx*sy, cx*cy, sx*sy, with cz/sz carried.
    fix_t p_reg [0:3];
    fix_t sz_reg;
    fix_t cz_reg;
    logic signed [PW-1:0] t_reg [0:7];
    logic signed [PW-1:0] pr [0:3];
    logic signed [PW:0] sum [0:3];
    logic signed [PW:0] rnd [0:3];
    logic signed [OUT_WIDTH-1:0] res [0:3];

    always_comb
    begin
        pr[0] = (PW'(sx) * PW'(cy) + RND1) >>> FRAC;
        pr[1] = (PW'(cx) * PW'(sy) + RND1) >>> FRAC;
        pr[2] = (PW'(cx) * PW'(cy) + RND1) >>> FRAC;
        pr[3] = (PW'(sx) * PW'(sy) + RND1) >>> FRAC;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                p_reg[k] <= IW'(pr[k]);
            end
            sz_reg <= sz;
            cz_reg <= cz;
            t_reg[0] <= PW'(p_reg[0]) * PW'(cz_reg);
            t_reg[1] <= PW'(p_reg[1]) * PW'(sz_reg);
            t_reg[2] <= PW'(p_reg[1]) * PW'(cz_reg);
            t_reg[3] <= PW'(p_reg[0]) * PW'(sz_reg);
            t_reg[4] <= PW'(p_reg[2]) * PW'(sz_reg);
            t_reg[5] <= PW'(p_reg[3]) * PW'(cz_reg);
            t_reg[6] <= PW'(p_reg[2]) * PW'(cz_reg);
            t_reg[7] <= PW'(p_reg[3]) * PW'(sz_reg);
            qx <= res[0];
            qy <= res[1];
            qz <= res[2];
            qw <= res[3];
        end
    end

    always_comb
    begin
        sum[0] = (PW + 1)'(t_reg[0]) - (PW + 1)'(t_reg[1]);
        sum[1] = (PW + 1)'(t_reg[2]) + (PW + 1)'(t_reg[3]);
        sum[2] = (PW + 1)'(t_reg[4]) - (PW + 1)'(t_reg[5]);
        sum[3] = (PW + 1)'(t_reg[6]) + (PW + 1)'(t_reg[7]);
        for (int k = 0; k < 4; k++)
        begin
            rnd[k] = (sum[k] + RND2) >>> SH;
            if (rnd[k] > LIM)
            begin
                res[k] = OUT_WIDTH'(LIM);
            end
            else if (rnd[k] < -LIM)
            begin
                res[k] = OUT_WIDTH'(-LIM);
            end
            else
            begin
                res[k] = OUT_WIDTH'(rnd[k]);
            end
        end
    end
endmodule

[rtl/euler_to_quaternion_top.sv]
// Euler angles (ZYX) to unit quaternion, fully pipelined.
// Each input passes the CORDIC input and step registers, then the e2q_combine stages.
// Throughput: one transaction per cycle unless a held result waits on out_ready; the CORDIC stage count sets latency.
// A stall freezes the whole pipeline; valid bits clear on rst_n low.
// Depends on e2q_pkg, e2q_cordic and e2q_combine.
`timescale 1ns / 1ps
module euler_to_quaternion_top #(
    parameter int ANGLE_WIDTH = e2q_pkg::ANGLE_WIDTH_DEF,
    parameter int OUT_WIDTH = e2q_pkg::OUT_WIDTH_DEF,
    parameter int CORDIC_STEPS = e2q_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [ANGLE_WIDTH-1:0] roll_angle,
    input  logic signed [ANGLE_WIDTH-1:0] pitch_angle,
    input  logic signed [ANGLE_WIDTH-1:0] yaw_angle,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [OUT_WIDTH-1:0]   quat_x,
    output logic signed [OUT_WIDTH-1:0]   quat_y,
    output logic signed [OUT_WIDTH-1:0]   quat_z,
    output logic signed [OUT_WIDTH-1:0]   quat_w
);
    import e2q_pkg::*;

    localparam int NS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int DEPTH = NS + 4;

    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic en;
    fix_t sx, cx, sy, cy, sz, cz;

    // The pipeline advances when the last stage is empty or being taken.
    assign en = !vld_reg[DEPTH-1] || out_ready;
    assign in_ready = en;
    assign out_valid = vld_reg[DEPTH-1];
    assign vld_next = {vld_reg[DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    e2q_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_cx (
        .clk(clk), .en(en), .angle(roll_angle), .sin_val(sx), .cos_val(cx)
    );
    e2q_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_cy (
        .clk(clk), .en(en), .angle(pitch_angle), .sin_val(sy), .cos_val(cy)
    );
    e2q_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_cz (
        .clk(clk), .en(en), .angle(yaw_angle), .sin_val(sz), .cos_val(cz)
    );

    e2q_combine #(.OUT_WIDTH(OUT_WIDTH)) u_comb (
        .clk(clk), .en(en),
        .sx(sx), .cx(cx), .sy(sy), .cy(cy), .sz(sz), .cz(cz),
        .qx(quat_x), .qy(quat_y), .qz(quat_z), .qw(quat_w)
    );

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready) else $error("input blocked with empty output");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(quat_w))
        else $error("stalled result changed");
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> quat_w <= (OUT_WIDTH'(1) <<< (OUT_WIDTH - 2)))
        else $error("w beyond one");
endmodule

[test/tb_top.sv]
// Testbench for euler_to_quaternion_top: directed angle table, then random angle triples.
// Expected quaternions come from the table where known, else from a local fixed-point CORDIC predictor, in order.
// Depends on e2q_pkg and the converter RTL.
`timescale 1ns / 1ps
module tb_top;
    import e2q_pkg::*;

    localparam int AW = 16;
    localparam int OW = 16;
    localparam int STEPS = 16;
    localparam int NUM_RANDOM = 900;
    localparam logic signed [OW-1:0] ONE = 16'sd16384;

    typedef struct packed {
        logic signed [OW-1:0] x;
        logic signed [OW-1:0] y;
        logic signed [OW-1:0] z;
        logic signed [OW-1:0] w;
    } quat_t;

    typedef struct {
        logic signed [AW-1:0] roll;
        logic signed [AW-1:0] pitch;
        logic signed [AW-1:0] yaw;
        bit                   known;
        quat_t                q;
    } angle_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [AW-1:0] roll_angle;
    logic signed [AW-1:0] pitch_angle;
    logic signed [AW-1:0] yaw_angle;
    logic                 out_valid;
    logic                 out_ready;
    logic signed [OW-1:0] quat_x;
    logic signed [OW-1:0] quat_y;
    logic signed [OW-1:0] quat_z;
    logic signed [OW-1:0] quat_w;

    quat_t      expected_quats[$];
    angle_row_t angle_table[$];
    int         mismatches;
    bit         stimulus_done;

    euler_to_quaternion_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .roll_angle(roll_angle),
        .pitch_angle(pitch_angle),
        .yaw_angle(yaw_angle),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .quat_x(quat_x),
        .quat_y(quat_y),
        .quat_z(quat_z),
        .quat_w(quat_w)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic longint arctan_step(input int i);
        longint t[16];
        t = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
              16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
              131071, 65535, 32767};
        return t[i];
    endfunction

    task automatic half_sin_cos(input logic signed [AW-1:0] ang,
                                output longint s, output longint c);
        longint h;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        region_t reg_sel;
        h = longint'(ang) <<< (32 - AW);
        x = 652032874;
        y = 0;
        reg_sel = REG_MID;
        z = h;
        if (h > 1686629713)
        begin
            z = h - 1686629713;
            reg_sel = REG_POS;
        end
        else if (h < -1686629713)
        begin
            z = h + 1686629713;
            reg_sel = REG_NEG;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_step(i);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_step(i);
            end
        end
        case (reg_sel)
            REG_POS:
            begin
                s = x;
                c = -y;
            end
            REG_NEG:
            begin
                s = -x;
                c = y;
            end
            default:
            begin
                s = y;
                c = x;
            end
        endcase
    endtask

    function automatic longint triple_product(input longint a, input longint b, input longint c);
        longint t;
        t = (a * b + (longint'(1) <<< 29)) >>> 30;
        return t * c;
    endfunction

    function automatic logic signed [OW-1:0] round_saturate(input longint v);
        longint r;
        r = (v + (longint'(1) <<< (60 - (OW - 2) - 1))) >>> (60 - (OW - 2));
        if (r > 16384)
            r = 16384;
        if (r < -16384)
            r = -16384;
        return r[OW-1:0];
    endfunction

    task automatic predict_quat(input logic signed [AW-1:0] roll,
                                input logic signed [AW-1:0] pitch,
                                input logic signed [AW-1:0] yaw, output quat_t q);
        longint sx;
        longint cx;
        longint sy;
        longint cy;
        longint sz;
        longint cz;
        half_sin_cos(roll, sx, cx);
        half_sin_cos(pitch, sy, cy);
        half_sin_cos(yaw, sz, cz);
        q.x = round_saturate(triple_product(sx, cy, cz) - triple_product(cx, sy, sz));
        q.y = round_saturate(triple_product(cx, sy, cz) + triple_product(sx, cy, sz));
        q.z = round_saturate(triple_product(cx, cy, sz) - triple_product(sx, sy, cz));
        q.w = round_saturate(triple_product(cx, cy, cz) + triple_product(sx, sy, sz));
    endtask

    task automatic add_row(input int r, input int p, input int y, input bit known,
                           input quat_t q);
        angle_row_t row;
        row.roll = r[AW-1:0];
        row.pitch = p[AW-1:0];
        row.yaw = y[AW-1:0];
        row.known = known;
        row.q = q;
        angle_table.push_back(row);
    endtask

    task automatic send_triple(input logic signed [AW-1:0] r, input logic signed [AW-1:0] p,
                               input logic signed [AW-1:0] y, input quat_t q);
        in_valid <= 1'b1;
        roll_angle <= r;
        pitch_angle <= p;
        yaw_angle <= y;
        expected_quats.push_back(q);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    initial
    begin
        int gap;
        int burst;
        quat_t q;
        logic signed [AW-1:0] r;
        logic signed [AW-1:0] p;
        logic signed [AW-1:0] y;
        rst_n = 1'b0;
        in_valid = 1'b0;
        roll_angle = '0;
        pitch_angle = '0;
        yaw_angle = '0;
        mismatches = 0;
        stimulus_done = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(0, 0, 0, 1'b1, '{x: 16'sd0, y: 16'sd0, z: 16'sd0, w: ONE});
        add_row(32767, 0, 0, 1'b0, '0);
        add_row(-32768, 0, 0, 1'b0, '0);
        add_row(0, 32767, 0, 1'b0, '0);
        add_row(0, -32768, 0, 1'b0, '0);
        add_row(0, 0, 32767, 1'b0, '0);
        add_row(0, 0, -32768, 1'b0, '0);
        add_row(32767, 32767, 32767, 1'b0, '0);
        add_row(-32768, -32768, -32768, 1'b0, '0);
        add_row(25736, 0, 0, 1'b0, '0);
        add_row(-25736, 0, 0, 1'b0, '0);
        add_row(0, 25737, -25737, 1'b0, '0);
        add_row(12868, 12868, 12868, 1'b0, '0);
        add_row(-1, 1, -1, 1'b0, '0);
        add_row(-21846, 21845, 10922, 1'b0, '0);
        add_row(27000, -27000, 30000, 1'b0, '0);

        foreach (angle_table[i])
        begin
            if (angle_table[i].known)
                q = angle_table[i].q;
            else
                predict_quat(angle_table[i].roll, angle_table[i].pitch, angle_table[i].yaw, q);
            send_triple(angle_table[i].roll, angle_table[i].pitch, angle_table[i].yaw, q);
        end

        for (int n = 0; n < NUM_RANDOM; )
        begin
            burst = $urandom_range(1, 30);
            for (int k = 0; k < burst && n < NUM_RANDOM; k++, n++)
            begin
                r = AW'($urandom);
                p = AW'($urandom);
                y = AW'($urandom);
                predict_quat(r, p, y, q);
                send_triple(r, p, y, q);
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    initial
    begin
        int phase;
        out_ready = 1'b0;
        phase = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            phase = (phase + 1) % 64;
            if (phase < 20)
                out_ready <= 1'b1;
            else if (phase < 40)
                out_ready <= ($urandom_range(0, 2) != 0);
            else
                out_ready <= ((phase % 7) != 0) && ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        quat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_quats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: x=%0d y=%0d z=%0d w=%0d",
                             quat_x, quat_y, quat_z, quat_w);
            end
            else
            begin
                want = expected_quats.pop_front();
                if (quat_x !== want.x || quat_y !== want.y || quat_z !== want.z
                    || quat_w !== want.w)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                 want.x, want.y, want.z, want.w,
                                 quat_x, quat_y, quat_z, quat_w);
                end
            end
        end
    end

    initial
    begin
        wait (stimulus_done);
        while (expected_quats.size() != 0)
            @(posedge clk);
        repeat (STEPS + 10) @(posedge clk);
        if (mismatches == 0 && expected_quats.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb_top: errors");
        $finish;
    end
endmodule

[filelist.f]
rtl/e2q_pkg.sv
rtl/e2q_cordic.sv
rtl/e2q_combine.sv
rtl/euler_to_quaternion_top.sv
test/tb_top.sv
